/* sv/ffa_pkg.sv */
package ffa_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 4;
   localparam int ALIGN_BYTES_DEF  = 16;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 24;
   localparam int LEN_W      = 25;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_BREAK_WRAP = 2'd2;
   localparam logic [1:0] ST_BAD_FREE   = 2'd3;

   // register index, taken from csr_paddr[2]
   localparam logic REG_HEAP_START = 1'b0;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic              from_free_list;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
      logic              is_free;
   } blk_entry_type;

endpackage

/* sv/ffa_block_table.sv */
module ffa_block_table
   import ffa_pkg::*;
#(
   parameter int DEPTH = MAX_BLOCKS_DEF,
   parameter int IW    = $clog2(MAX_BLOCKS_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  blk_entry_type wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output blk_entry_type rd_data
);

   blk_entry_type mem_ff [DEPTH];
   blk_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ffa_free_stack.sv */
module ffa_free_stack
   import ffa_pkg::*;
#(
   parameter int DEPTH = MAX_BLOCKS_DEF,
   parameter int IW    = $clog2(MAX_BLOCKS_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [IW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [IW-1:0] rd_data
);

   logic [IW-1:0] mem_ff [DEPTH];
   logic [IW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/first_fit_free_list_allocator.sv */
// Allocate: scans the free list from the head, one entry a cycle through the stack and
// block-table read ports; when no entry fits, or the list is empty, it tries to carve a new
// block, then loads the output; a hit moves each entry above it in the stack down by one.
// Free: scans the carved blocks for the address, one block-table read a cycle.
// One item in work at a time; the next is taken while a result waits in the output.
// Synchronous reset clears control state and counts; the tables need no clearing pass.
module first_fit_free_list_allocator
   import ffa_pkg::*;
#(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ASCAN = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_AMISS = 3'd3;
   localparam logic [2:0] S_FSCAN = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  rounded_ff, rounded_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              v1_ff, v1_in;
   logic [IW-1:0]     pos1_ff, pos1_in;
   logic              v2_ff, v2_in;
   logic [IW-1:0]     pos2_ff, pos2_in;
   logic [IW-1:0]     idx2_ff, idx2_in;
   logic [CW-1:0]     sh_next_ff, sh_next_in;
   logic [IW-1:0]     sh_wa_ff, sh_wa_in;
   logic [IW-1:0]     fidx_ff, fidx_in;
   rsp_type           res_ff, res_in;
   logic [CW-1:0]     block_count_ff, block_count_in;
   logic [CW-1:0]     free_count_ff, free_count_in;
   logic [ADDR_W-1:0] heap_break_ff, heap_break_in;
   logic [ADDR_W-1:0] heap_start_ff, heap_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              blk_we, blk_re;
   logic [IW-1:0]     blk_wa, blk_ra;
   blk_entry_type     blk_wd, blk_rd;
   logic              stk_we, stk_re;
   logic [IW-1:0]     stk_wa, stk_ra, stk_wd, stk_rd;

   logic [ADDR_W-1:0] rnd_sum, rnd_val;
   logic [CW-1:0]     fc_m1, scan_m1, pos2_p1, sh_nm1;
   logic [ADDR_W:0]   brk_sum;
   logic              hit, match, out_free, cfg_wr;

   ffa_block_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_blk (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_wa),
      .wr_data (blk_wd),
      .rd_en   (blk_re),
      .rd_addr (blk_ra),
      .rd_data (blk_rd)
   );

   ffa_free_stack #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   assign rnd_sum  = ADDR_W'(req_data.request_size) + ADDR_W'(HEADER_BYTES)
                   + ADDR_W'(ALIGN_BYTES - 1);
   assign rnd_val  = rnd_sum & ~(ADDR_W'(ALIGN_BYTES - 1));
   assign fc_m1    = free_count_ff - CW'(1);
   assign scan_m1  = scan_ff - CW'(1);
   assign pos2_p1  = CW'(pos2_ff) + CW'(1);
   assign sh_nm1   = sh_next_ff - CW'(1);
   assign brk_sum  = {1'b0, heap_break_ff} + (ADDR_W + 1)'(rounded_ff);
   assign hit      = v2_ff && (blk_rd.length >= rounded_ff);
   assign match    = (blk_rd.start + ADDR_W'(HEADER_BYTES)) == addr_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_HEAP_START);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      rounded_in     = rounded_ff;
      scan_in        = scan_ff;
      v1_in          = v1_ff;
      pos1_in        = pos1_ff;
      v2_in          = v2_ff;
      pos2_in        = pos2_ff;
      idx2_in        = idx2_ff;
      sh_next_in     = sh_next_ff;
      sh_wa_in       = sh_wa_ff;
      fidx_in        = fidx_ff;
      res_in         = res_ff;
      block_count_in = block_count_ff;
      free_count_in  = free_count_ff;
      heap_break_in  = heap_break_ff;
      heap_start_in  = heap_start_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      blk_we         = 1'b0;
      blk_wa         = '0;
      blk_wd         = blk_rd;
      blk_re         = 1'b0;
      blk_ra         = '0;
      stk_we         = 1'b0;
      stk_wa         = '0;
      stk_wd         = '0;
      stk_re         = 1'b0;
      stk_ra         = '0;

      if (cfg_wr) begin
         heap_start_in = csr_pwdata;
         if (block_count_ff == '0) begin
            heap_break_in = csr_pwdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               addr_in    = req_data.release_address;
               rounded_in = rnd_val[LEN_W-1:0];
               if (req_data.command == CMD_ALLOC) begin
                  if (free_count_ff != '0) begin
                     // start at the head: most recently freed block
                     stk_re   = 1'b1;
                     stk_ra   = fc_m1[IW-1:0];
                     pos1_in  = fc_m1[IW-1:0];
                     v1_in    = 1'b1;
                     v2_in    = 1'b0;
                     scan_in  = fc_m1;
                     state_in = S_ASCAN;
                  end else begin
                     state_in = S_AMISS;
                  end
               end else begin
                  if (block_count_ff != '0) begin
                     blk_re   = 1'b1;
                     blk_ra   = '0;
                     fidx_in  = '0;
                     scan_in  = CW'(1);
                     state_in = S_FSCAN;
                  end else begin
                     res_in   = '{payload_address: '0, from_free_list: 1'b0,
                                  status: ST_BAD_FREE};
                     state_in = S_DONE;
                  end
               end
            end
         end

         S_ASCAN: begin
            if (hit) begin
               blk_we         = 1'b1;
               blk_wa         = idx2_ff;
               blk_wd.is_free = 1'b0;
               res_in         = '{payload_address: blk_rd.start + ADDR_W'(HEADER_BYTES),
                                  from_free_list: 1'b1, status: ST_OK};
               v1_in          = 1'b0;
               v2_in          = 1'b0;
               if (pos2_p1 < free_count_ff) begin
                  // close the gap: move entries above the hit down by one
                  stk_re     = 1'b1;
                  stk_ra     = pos2_p1[IW-1:0];
                  sh_wa_in   = pos2_ff;
                  sh_next_in = pos2_p1 + CW'(1);
                  state_in   = S_SHIFT;
               end else begin
                  free_count_in = fc_m1;
                  state_in      = S_DONE;
               end
            end else begin
               v2_in   = v1_ff;
               pos2_in = pos1_ff;
               idx2_in = stk_rd;
               if (v1_ff) begin
                  blk_re = 1'b1;
                  blk_ra = stk_rd;
               end
               if (scan_ff != '0) begin
                  stk_re  = 1'b1;
                  stk_ra  = scan_m1[IW-1:0];
                  pos1_in = scan_m1[IW-1:0];
                  v1_in   = 1'b1;
                  scan_in = scan_m1;
               end else begin
                  v1_in = 1'b0;
               end
               if (scan_ff == '0 && !v1_ff) begin
                  state_in = S_AMISS;
               end
            end
         end

         S_SHIFT: begin
            stk_we = 1'b1;
            stk_wa = sh_wa_ff;
            stk_wd = stk_rd;
            if (sh_next_ff < free_count_ff) begin
               stk_re     = 1'b1;
               stk_ra     = sh_next_ff[IW-1:0];
               sh_wa_in   = sh_nm1[IW-1:0];
               sh_next_in = sh_next_ff + CW'(1);
            end else begin
               free_count_in = fc_m1;
               state_in      = S_DONE;
            end
         end

         S_AMISS: begin
            if (block_count_ff >= CW'(MAX_BLOCKS)) begin
               res_in = '{payload_address: '0, from_free_list: 1'b0, status: ST_TABLE_FULL};
            end else if (brk_sum[ADDR_W]) begin
               res_in = '{payload_address: '0, from_free_list: 1'b0, status: ST_BREAK_WRAP};
            end else begin
               blk_we         = 1'b1;
               blk_wa         = block_count_ff[IW-1:0];
               blk_wd         = '{start: heap_break_ff, length: rounded_ff, is_free: 1'b0};
               block_count_in = block_count_ff + CW'(1);
               heap_break_in  = brk_sum[ADDR_W-1:0];
               res_in         = '{payload_address: heap_break_ff + ADDR_W'(HEADER_BYTES),
                                  from_free_list: 1'b0, status: ST_OK};
            end
            state_in = S_DONE;
         end

         S_FSCAN: begin
            if (match) begin
               if (blk_rd.is_free || free_count_ff >= CW'(MAX_BLOCKS)) begin
                  res_in = '{payload_address: '0, from_free_list: 1'b0, status: ST_BAD_FREE};
               end else begin
                  blk_we         = 1'b1;
                  blk_wa         = fidx_ff;
                  blk_wd.is_free = 1'b1;
                  stk_we         = 1'b1;
                  stk_wa         = free_count_ff[IW-1:0];
                  stk_wd         = fidx_ff;
                  free_count_in  = free_count_ff + CW'(1);
                  res_in         = '{payload_address: '0, from_free_list: 1'b0, status: ST_OK};
               end
               state_in = S_DONE;
            end else if (scan_ff < block_count_ff) begin
               blk_re  = 1'b1;
               blk_ra  = scan_ff[IW-1:0];
               fidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
            end else begin
               res_in   = '{payload_address: '0, from_free_list: 1'b0, status: ST_BAD_FREE};
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         block_count_ff <= '0;
         free_count_ff  <= '0;
         heap_break_ff  <= '0;
         heap_start_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         block_count_ff <= block_count_in;
         free_count_ff  <= free_count_in;
         heap_break_ff  <= heap_break_in;
         heap_start_ff  <= heap_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      rounded_ff <= rounded_in;
      scan_ff    <= scan_in;
      pos1_ff    <= pos1_in;
      pos2_ff    <= pos2_in;
      idx2_ff    <= idx2_in;
      sh_next_ff <= sh_next_in;
      sh_wa_ff   <= sh_wa_in;
      fidx_ff    <= fidx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HEAP_START) ? heap_start_ff : '0;

endmodule

/* sv/ffa_checker.sv */
module ffa_checker
   import ffa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: the engine is busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while engine busy");

   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.payload_address == '0 && !rsp_data.from_free_list)
      else $error("failed item carries an address");

   a_reuse_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.from_free_list |-> rsp_data.status == ST_OK)
      else $error("reused block flagged with error status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
